/* hw/rtl/kplc_pkg.sv */
// ============================================================================
// kplc_pkg - shared types and constants of the key press length classifier
// Widths of the stream fields, register indexes and reset values.
// ============================================================================
package kplc_pkg;

  localparam int unsigned LINES_W = 5;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned LIMIT_W = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  // All five active-low lines released.
  localparam logic [LINES_W-1:0] LINES_ALL_HIGH = 5'h1f;

  localparam logic [CODE_W-1:0] KEY_NONE = 3'd0;

  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET = 16'd200;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RESET  = 16'd500;

  typedef enum logic [0:0] {
    CFG_SHORT_LIMIT = 1'b0,
    CFG_LONG_LIMIT  = 1'b1
  } cfg_index_e;

  typedef enum logic [0:0] {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } press_kind_e;

endpackage

/* hw/rtl/key_press_length_classifier_unit.sv */
// ============================================================================
// key_press_length_classifier_unit - short/long key press detector
// Classifies polls of five active-low key lines into short and long presses.
// ============================================================================
//
//  Channel  | Direction | Handshake                        | Payload
//  ---------+-----------+----------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready    | key_lines_n, now_ms
//  m_axis   | out       | m_axis_tvalid / m_axis_tready    | key_code (tdata), kind (tuser)
//  cfg      | in        | cfg_valid_i / cfg_ready_o        | cfg_index_i, cfg_data_i
//
// A poll request accepted at one edge is captured in the input register, and its report,
// if any, is classified from there and written into the result register.
// One request is accepted every cycle while the result side keeps up, since the press and
// release times are updated in a single pass. Reset clears the timestamps, the held key
// and the valid flags and loads the default limits (200 ms short, 500 ms long). A stalled
// result register holds the input register, s_axis_tready drops only when both are full,
// and configuration writes are always accepted.

module key_press_length_classifier_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: key_lines_n [4:0], now_ms [36:5], zero pad [39:37].
  input  logic [kplc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: key_code [2:0], zero pad [7:3].
  output logic [kplc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0 up: press_kind [0].
  output logic                                m_axis_tuser,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [kplc_pkg::LIMIT_W-1:0]        cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [kplc_pkg::LIMIT_W-1:0] short_limit_q, short_limit_d;
  logic [kplc_pkg::LIMIT_W-1:0] long_limit_q, long_limit_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    short_limit_d = short_limit_q;
    long_limit_d  = long_limit_q;
    if (cfg_valid_i) begin
      unique case (kplc_pkg::cfg_index_e'(cfg_index_i))
        kplc_pkg::CFG_SHORT_LIMIT: short_limit_d = cfg_data_i;
        kplc_pkg::CFG_LONG_LIMIT:  long_limit_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_limit_q <= kplc_pkg::SHORT_LIMIT_RESET;
      long_limit_q  <= kplc_pkg::LONG_LIMIT_RESET;
    end else begin
      short_limit_q <= short_limit_d;
      long_limit_q  <= long_limit_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. It advances whenever the result register is free or
  // being emptied in this cycle.
  // --------------------------------------------------------------------------
  logic                           in_valid_q, in_valid_d;
  logic [kplc_pkg::LINES_W-1:0]   in_lines_q;
  logic [kplc_pkg::STAMP_W-1:0]   in_stamp_q;
  logic                           advance;
  logic                           out_valid_q, out_valid_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_lines_q <= s_axis_tdata[kplc_pkg::LINES_W-1:0];
      in_stamp_q <= s_axis_tdata[kplc_pkg::LINES_W +: kplc_pkg::STAMP_W];
    end
  end

  // The timestamp is used modulo 2^TIME_WIDTH; wider timers see zeros on top.
  logic [TIME_WIDTH-1:0] now_t;

  if (TIME_WIDTH > kplc_pkg::STAMP_W) begin : g_stamp_ext
    assign now_t = {{(TIME_WIDTH - kplc_pkg::STAMP_W){1'b0}}, in_stamp_q};
  end else begin : g_stamp_trunc
    assign now_t = in_stamp_q[TIME_WIDTH-1:0];
  end

  // --------------------------------------------------------------------------
  // Classification. The new press and release times feed the difference in
  // the same pass that stores them.
  // --------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0]        release_q, release_d;
  logic [TIME_WIDTH-1:0]        press_q, press_d;
  logic [kplc_pkg::CODE_W-1:0]  held_q, held_d, held_new;
  logic [TIME_WIDTH-1:0]        diff;
  logic [TIME_WIDTH-1:0]        mag;
  logic                         report;
  logic                         kind;
  logic                         any_low;

  always_comb begin
    release_d = release_q;
    press_d   = press_q;
    held_new  = held_q;
    any_low   = 1'b0;

    if (in_lines_q == kplc_pkg::LINES_ALL_HIGH) begin
      release_d = now_t;
    end

    // The highest-numbered low line wins.
    for (int unsigned i = 0; i < kplc_pkg::LINES_W; i++) begin
      if (!in_lines_q[i]) begin
        held_new = kplc_pkg::CODE_W'(i + 1);
        any_low  = 1'b1;
      end
    end
    if (any_low) begin
      press_d = now_t;
    end

    diff   = release_d - press_d;
    mag    = '0 - diff;
    report = 1'b0;
    kind   = kplc_pkg::KIND_SHORT;

    if (held_new != kplc_pkg::KEY_NONE) begin
      if (!diff[TIME_WIDTH-1]) begin
        // Release came after the press: short when inside the window.
        if (diff < {{(TIME_WIDTH - kplc_pkg::LIMIT_W){1'b0}}, short_limit_q}) begin
          report = 1'b1;
        end
      end else begin
        // Press is later than release: the key is still held.
        if (mag > {{(TIME_WIDTH - kplc_pkg::LIMIT_W){1'b0}}, long_limit_q}) begin
          report = 1'b1;
          kind   = kplc_pkg::KIND_LONG;
        end
      end
    end

    held_d = report ? kplc_pkg::KEY_NONE : held_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      release_q <= '0;
      press_q   <= '0;
      held_q    <= kplc_pkg::KEY_NONE;
    end else if (in_valid_q && advance) begin
      release_q <= release_d;
      press_q   <= press_d;
      held_q    <= held_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic [kplc_pkg::CODE_W-1:0] out_code_q;
  logic                        out_kind_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q && report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && report) begin
      out_code_q <= held_new;
      out_kind_q <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(kplc_pkg::OUT_TDATA_W - kplc_pkg::CODE_W){1'b0}}, out_code_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
